>>> sv/skvt_pkg.sv
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types and constants for the sorted key/value table core.
// ----------------------------------------------------------------------------
package skvt_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int KEY_W     = 32;
    localparam int VALUE_W   = 32;
    localparam int MODE_W    = 2;
    localparam int COUNT_W   = 9;

    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_SHIFT,
        S_MOVE
    } t_state;

endpackage

>>> sv/sorted_key_value_table_core.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table_core
// Key-to-value table kept in ascending key order in two single-port-read
// RAMs; halving search for lookups, ordered insert with shift-up, clear.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Ports
//  --------  -------------------  ---------------------------------------------
//  command   start & !busy        i_mode, i_key, i_entry_value
//  result    o_done (one cycle)   o_found, o_result_value, o_status, o_count
//
//  Steps: clear and the unused mode finish straight from idle; lookup in an empty
//  table too. Lookup runs one probe per halving step (up to ~clog2(DEPTH)+1
//  probes), the probe being one RAM read then a compare. Insert runs the same
//  halving search for its position, then a read and a write-back per entry
//  shifted up (the write-back on the single RAM write port) and a write of the new
//  pair. The result strobe comes the cycle after the last step; a new command
//  may be taken in that same cycle.
//  Reset: synchronous, active low; empties the table (count 0). RAM contents
//  are not cleared: entries at or above the count are never read.
//  The receiver cannot stall: o_done is high for exactly one cycle per word.
//
module sorted_key_value_table_core
    import skvt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [VALUE_W-1:0] i_entry_value,
    output logic               o_done,
    output logic               o_found,
    output logic [VALUE_W-1:0] o_result_value,
    output logic               o_status,
    output logic [COUNT_W-1:0] o_count
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Table storage: both arrays share address and write strobe.
    logic [KEY_W-1:0]   r_key_mem [DEPTH];
    logic [VALUE_W-1:0] r_val_mem [DEPTH];
    logic [KEY_W-1:0]   r_rd_key;
    logic [VALUE_W-1:0] r_rd_val;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [KEY_W-1:0]   mem_wkey;
    logic [VALUE_W-1:0] mem_wval;
    logic [ADDR_W-1:0]  mem_raddr;

    t_state             r_state, n_state;
    logic [MODE_W-1:0]  r_mode, n_mode;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [VALUE_W-1:0] r_val, n_val;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_lo, n_lo;      // search range low; insert position
    logic [CNT_W-1:0]   r_hi, n_hi;
    logic [CNT_W-1:0]   r_probe, n_probe;
    logic [CNT_W-1:0]   r_ptr, n_ptr;    // shift destination
    logic               r_done, n_done;
    logic               r_found, n_found;
    logic [VALUE_W-1:0] r_res, n_res;
    logic               r_status, n_status;

    logic [CNT_W-1:0]   span;
    logic [CNT_W-1:0]   mid;
    logic [CNT_W-1:0]   ptr_m1;
    logic [CNT_W-1:0]   lb_lo, lb_hi;
    logic               accept;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    assign accept = start && !busy;
    assign span   = r_hi - r_lo;
    assign mid    = r_lo + (span >> 1);
    assign ptr_m1 = r_ptr - CNT_W'(1);

    // Lower-bound step for insert: first entry whose key is not smaller.
    always_comb begin
        lb_lo = r_lo;
        lb_hi = r_hi;
        if (r_rd_key < r_key) begin
            lb_lo = r_probe + CNT_W'(1);
        end else begin
            lb_hi = r_probe;
        end
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_key     = r_key;
        n_val     = r_val;
        n_count   = r_count;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_probe   = r_probe;
        n_ptr     = r_ptr;
        n_done    = 1'b0;
        n_found   = r_found;
        n_res     = r_res;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wkey  = r_key;
        mem_wval  = r_val;
        mem_raddr = mid[ADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode   = i_mode;
                    n_key    = i_key;
                    n_val    = i_entry_value;
                    n_lo     = '0;
                    n_hi     = r_count;
                    n_found  = 1'b0;
                    n_res    = '0;
                    n_status = STATUS_OK;
                    priority if (i_mode == MODE_LOOKUP) begin
                        if (r_count == '0) begin
                            n_done = 1'b1;       // empty table: miss, no read
                        end else begin
                            n_state = S_PROBE;
                        end
                    end else if (i_mode == MODE_INSERT) begin
                        if (r_count == CNT_W'(DEPTH)) begin
                            n_status = STATUS_FULL;
                            n_done   = 1'b1;
                        end else if (r_count == '0) begin
                            n_ptr   = '0;
                            n_state = S_SHIFT;
                        end else begin
                            n_state = S_PROBE;
                        end
                    end else if (i_mode == MODE_CLEAR) begin
                        n_count = '0;
                        n_done  = 1'b1;
                    end else begin
                        n_done = 1'b1;           // unused code: no change
                    end
                end
            end

            S_PROBE: begin
                mem_raddr = mid[ADDR_W-1:0];
                n_probe   = mid;
                n_state   = S_CMP;
            end

            S_CMP: begin
                if (r_mode == MODE_LOOKUP) begin
                    if (r_rd_key == r_key) begin
                        n_found = 1'b1;
                        n_res   = r_rd_val;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else if (span <= CNT_W'(1)) begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else if (r_key < r_rd_key) begin
                        n_hi    = r_probe;
                        n_state = S_PROBE;
                    end else if (r_probe + CNT_W'(1) == r_hi) begin
                        n_done  = 1'b1;          // nothing left above the probe
                        n_state = S_IDLE;
                    end else begin
                        n_lo    = r_probe + CNT_W'(1);
                        n_state = S_PROBE;
                    end
                end else begin
                    n_lo = lb_lo;
                    n_hi = lb_hi;
                    if (lb_lo == lb_hi) begin
                        n_ptr   = r_count;
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_PROBE;
                    end
                end
            end

            S_SHIFT: begin
                if (r_ptr > r_lo) begin
                    mem_raddr = ptr_m1[ADDR_W-1:0];
                    n_state   = S_MOVE;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_lo[ADDR_W-1:0];
                    n_count   = r_count + CNT_W'(1);
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            S_MOVE: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr[ADDR_W-1:0];
                mem_wkey  = r_rd_key;
                mem_wval  = r_rd_val;
                n_ptr     = ptr_m1;
                n_state   = S_SHIFT;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_key    <= n_key;
        r_val    <= n_val;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_probe  <= n_probe;
        r_ptr    <= n_ptr;
        r_found  <= n_found;
        r_res    <= n_res;
        r_status <= n_status;
    end

    // ------------------------------------------------------------------
    // Table RAMs: one write, one registered read per cycle
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_key_mem[mem_waddr] <= mem_wkey;
            r_val_mem[mem_waddr] <= mem_wval;
        end
        r_rd_key <= r_key_mem[mem_raddr];
        r_rd_val <= r_val_mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign count_ext      = {{COUNT_W{1'b0}}, r_count};
    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_found        = r_found;
    assign o_result_value = r_res;
    assign o_status       = r_status;
    assign o_count        = count_ext[COUNT_W-1:0];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above table depth");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (r_count == CNT_W'(DEPTH)))
        else $error("full status with free entries");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_found) |-> (o_result_value == '0))
        else $error("nonzero value on miss");

    a_shift_above_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE) |-> (r_ptr > r_lo))
        else $error("shift pointer at or below insert position");

    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_done) |-> $past(busy || start))
        else $error("result strobe without a command");

endmodule

>>> bench/tb_sorted_key_value_table_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_key_value_table_core
// Self-checking bench for the sorted key/value table core. A clocked driver
// feeds command words from a backlog queue. A clocked monitor runs an
// in-bench shadow of the table on every accepted word and checks each result
// strobe against the oldest prediction. Stimulus: a directed set of edge
// cases, one pass that fills the table to capacity, then random phases.
// ----------------------------------------------------------------------------
module tb_sorted_key_value_table_core;
    import skvt_pkg::*;

    localparam int TABLE_DEPTH  = DEPTH_DEF;
    localparam int RANDOM_WORDS = 950;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int TAIL_CYCLES  = 64;

    // mode 3 has no name in the package; the core treats it as a no-op
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        int unsigned        idle_after;
    } t_cmd_word;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] value;
        logic               status;
        logic [COUNT_W-1:0] count;
    } t_table_result;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               start          = 1'b0;
    logic               busy;
    logic [MODE_W-1:0]  i_mode         = MODE_LOOKUP;
    logic [KEY_W-1:0]   i_key          = '0;
    logic [VALUE_W-1:0] i_entry_value  = '0;
    logic               o_done;
    logic               o_found;
    logic [VALUE_W-1:0] o_result_value;
    logic               o_status;
    logic [COUNT_W-1:0] o_count;

    // shadow of the table contents, sorted ascending like the core's RAMs
    logic [KEY_W-1:0]   shadow_keys   [TABLE_DEPTH];
    logic [VALUE_W-1:0] shadow_values [TABLE_DEPTH];
    int                 shadow_count = 0;

    t_cmd_word          cmd_backlog [$];
    t_table_result      expected_results [$];
    logic [KEY_W-1:0]   known_keys [$];

    int                 words_total = 0;
    int                 words_taken = 0;
    int                 err_count   = 0;
    int                 cycle_count = 0;
    int unsigned        idle_left   = 0;
    logic               word_taken  = 1'b0;
    bit                 quiet_phase = 1'b1;

    sorted_key_value_table_core #(
        .DEPTH(TABLE_DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_key          (i_key),
        .i_entry_value  (i_entry_value),
        .o_done         (o_done),
        .o_found        (o_found),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_count        (o_count)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Applies one command word to the shadow table and returns the result the
    // core must give for it.
    function automatic t_table_result table_apply(logic [MODE_W-1:0] mode,
                                                  logic [KEY_W-1:0] key,
                                                  logic [VALUE_W-1:0] value);
        t_table_result r;
        int            lo;
        int            hi;
        int            probe;
        int            slot;
        int            j;
        bit            searching;
        r = '0;
        case (mode)
            MODE_LOOKUP: begin
                // halving search over [lo, hi); with equal keys the first one
                // probed wins, so the probe order has to match exactly
                lo = 0;
                hi = shadow_count;
                searching = 1'b1;
                while (searching && lo < hi) begin
                    probe = lo + (hi - lo) / 2;
                    if (shadow_keys[probe] == key) begin
                        r.found = 1'b1;
                        r.value = shadow_values[probe];
                        searching = 1'b0;
                    end else if (hi - lo <= 1) begin
                        searching = 1'b0;
                    end else if (key < shadow_keys[probe]) begin
                        hi = probe;
                    end else begin
                        lo = probe + 1;
                    end
                end
            end
            MODE_INSERT: begin
                if (shadow_count >= TABLE_DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    // new pair goes after smaller keys, ahead of equal ones
                    slot = 0;
                    while (slot < shadow_count && shadow_keys[slot] < key) slot++;
                    for (j = shadow_count; j > slot; j--) begin
                        shadow_keys[j]   = shadow_keys[j-1];
                        shadow_values[j] = shadow_values[j-1];
                    end
                    shadow_keys[slot]   = key;
                    shadow_values[slot] = value;
                    shadow_count++;
                end
            end
            MODE_CLEAR: begin
                shadow_count = 0;
            end
            default: begin
            end
        endcase
        r.count = COUNT_W'(shadow_count);
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
            err_count++;
        end
    endtask

    task automatic queue_word(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                              logic [VALUE_W-1:0] value);
        t_cmd_word w;
        w.mode       = mode;
        w.key        = key;
        w.value      = value;
        w.idle_after = quiet_phase ? 0 : $urandom_range(0, 9);
        cmd_backlog.push_back(w);
        words_total++;
        if (mode == MODE_INSERT) known_keys.push_back(key);
        if (mode == MODE_CLEAR) known_keys.delete();
    endtask

    // narrow keys crowd a few values at both ends so equal keys pile up
    function automatic logic [KEY_W-1:0] pick_key(bit narrow);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: begin
                if (!narrow) return $urandom();
                if ($urandom_range(0, 1) == 0) return KEY_W'($urandom_range(0, 15));
                return 32'hFFFF_FFF0 | KEY_W'($urandom_range(0, 15));
            end
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] stored_key_pick();
        if (known_keys.size() == 0) return $urandom();
        return known_keys[$urandom_range(0, known_keys.size() - 1)];
    endfunction

    // Driver: inputs move on the falling edge. A word stays on the bus until
    // the monitor saw it taken (start & !busy) at the rising edge before.
    always @(negedge i_clk) begin : cmd_driver
        t_cmd_word w;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !word_taken) begin
            // core still busy, hold the word
        end else if (idle_left != 0 || cmd_backlog.size() == 0) begin
            start         <= 1'b0;
            // junk on the fields while start is low must be ignored
            i_mode        <= MODE_W'($urandom());
            i_key         <= $urandom();
            i_entry_value <= $urandom();
            if (idle_left != 0) idle_left <= idle_left - 1;
        end else begin
            w = cmd_backlog.pop_front();
            start         <= 1'b1;
            i_mode        <= w.mode;
            i_key         <= w.key;
            i_entry_value <= w.value;
            idle_left     <= w.idle_after;
        end
    end

    // Monitor: checks the result strobe first, then records a word taken at
    // this edge; a result and the next word can share an edge.
    always @(posedge i_clk) begin : result_monitor
        t_table_result want;
        if (!i_rst_n) begin
            word_taken <= 1'b0;
        end else begin
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, found %b value %h status %b count %h",
                             $time, o_found, o_result_value, o_status, o_count);
                    err_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("found", 32'(want.found), 32'(o_found));
                    check_field("result_value", want.value, o_result_value);
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("count", 32'(want.count), 32'(o_count));
                end
            end
            word_taken <= start && !busy;
            if (start && !busy) begin
                expected_results.push_back(table_apply(i_mode, i_key, i_entry_value));
                words_taken++;
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_sorted_key_value_table_core: errors");
        $finish;
    end

    initial begin : stimulus
        int random_start;
        int fill;
        int n;
        int pick;
        bit narrow;

        // directed, back to back
        queue_word(MODE_LOOKUP, '0, '1);                     // empty table, low key
        queue_word(MODE_LOOKUP, '1, '0);                     // empty table, high key
        queue_word(MODE_UNUSED, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
        queue_word(MODE_CLEAR, '1, '1);                      // clear when already empty
        queue_word(MODE_INSERT, '0, '1);
        queue_word(MODE_INSERT, '1, '0);
        queue_word(MODE_INSERT, 32'h8000_0000, 32'h1234_5678);
        queue_word(MODE_INSERT, 32'h8000_0000, 32'hEDCB_A987); // equal key lands ahead
        queue_word(MODE_INSERT, 32'h7FFF_FFFF, 32'h0000_0001);
        queue_word(MODE_LOOKUP, '0, '0);
        queue_word(MODE_LOOKUP, '1, '0);
        queue_word(MODE_LOOKUP, 32'h8000_0000, '0);
        queue_word(MODE_LOOKUP, 32'h7FFF_FFFF, '1);
        queue_word(MODE_LOOKUP, 32'h0000_0001, '0);          // miss between entries
        queue_word(MODE_LOOKUP, 32'hFFFF_FFFE, '0);          // miss just below the top
        queue_word(MODE_UNUSED, '1, '1);                     // no-op keeps the count
        queue_word(MODE_CLEAR, '0, '0);
        queue_word(MODE_LOOKUP, '0, '0);                     // stale entry must miss
        queue_word(MODE_INSERT, 32'h0000_0042, '1);
        queue_word(MODE_LOOKUP, 32'h0000_0041, '0);          // one-entry table, miss
        queue_word(MODE_LOOKUP, 32'h0000_0042, '0);          // one-entry table, hit

        // fill to capacity, then push against the full table
        random_start = words_total;
        quiet_phase = 1'b0;
        queue_word(MODE_CLEAR, $urandom(), $urandom());
        for (n = 0; n < TABLE_DEPTH; n++) begin
            queue_word(MODE_INSERT, pick_key(n[0]), $urandom());
            if (n % 16 == 15) queue_word(MODE_LOOKUP, stored_key_pick(), $urandom());
        end
        repeat (3) queue_word(MODE_INSERT, pick_key(1'b0), $urandom());
        repeat (12) queue_word(MODE_LOOKUP, stored_key_pick(), $urandom());
        queue_word(MODE_LOOKUP, pick_key(1'b0), $urandom());
        queue_word(MODE_UNUSED, $urandom(), $urandom());

        // random phases, mostly small tables so inserts stay short
        while (words_total - random_start < RANDOM_WORDS) begin
            quiet_phase = ($urandom_range(0, 3) == 0);
            narrow = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 3) != 0) queue_word(MODE_CLEAR, $urandom(), $urandom());
            fill = $urandom_range(1, 40);
            for (n = 0; n < fill; n++) begin
                pick = $urandom_range(0, 19);
                if (pick < 9)
                    queue_word(MODE_INSERT, pick_key(narrow), $urandom());
                else if (pick < 16)
                    queue_word(MODE_LOOKUP, stored_key_pick(), $urandom());
                else if (pick < 18)
                    queue_word(MODE_LOOKUP, pick_key(narrow), $urandom());
                else if (pick == 18)
                    queue_word(MODE_UNUSED, $urandom(), $urandom());
                else
                    queue_word(MODE_CLEAR, $urandom(), $urandom());
            end
        end

        while (words_taken != words_total) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("tb_sorted_key_value_table_core: clean");
        else
            $display("tb_sorted_key_value_table_core: errors");
        $finish;
    end

endmodule
